FILE: rtl/swmma_pkg.sv
// Shared types and constants for the sliding window min/max/mean core.
// No dependencies; imported by swmma_div and the top-level core.
`default_nettype none

package swmma_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int WINDOW_DEF = 64;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OLD,
        ST_SCAN
    } swmma_state_t;

endpackage : swmma_pkg

`default_nettype wire

FILE: rtl/swmma_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module swmma_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : swmma_ram

`default_nettype wire

FILE: rtl/swmma_div.sv
// Reciprocal-multiply divider of the running sum by the constant window size.
// Depends on swmma_pkg for the sample width.
`default_nettype none

module swmma_div
    import swmma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    parameter int SUM_W  = SAMPLE_W + $clog2(WINDOW)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [SUM_W-1:0]    dividend,
    output logic                     busy,
    output logic      [SAMPLE_W-1:0] quotient
);

    // floor(sum / WINDOW) equals floor(sum * RECIP / 2^SHIFT) for every sum below
    // 2^SUM_W, with RECIP = ceil(2^SHIFT / WINDOW). Multiply by RECIP one digit per
    // cycle, top digit first, and accumulate Horner style.
    localparam int SHIFT = SUM_W + $clog2(WINDOW);
    localparam int DIG_W = 16;
    localparam int NDIG  = (SUM_W + DIG_W) / DIG_W;
    localparam int RCP_W = NDIG * DIG_W;
    localparam int ACC_W = SUM_W + RCP_W;
    localparam int PRD_W = SUM_W + DIG_W;
    localparam int CNT_W = $clog2(NDIG + 1);
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_WIDE);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(NDIG);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] dvd_reg, dvd_next;
    logic [RCP_W-1:0] rcp_reg, rcp_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [PRD_W-1:0] partial;

    always_comb begin
        partial   = PRD_W'(dvd_reg) * PRD_W'(rcp_reg[RCP_W-1 -: DIG_W]);
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rcp_next  = rcp_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = STEPS;
            dvd_next  = dividend;
            rcp_next  = RECIP;
            acc_next  = '0;
        end else if (busy_reg) begin
            // Fold in the next reciprocal digit.
            acc_next = (acc_reg << DIG_W) + ACC_W'(partial);
            rcp_next = rcp_reg << DIG_W;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rcp_reg <= rcp_next;
        acc_reg <= acc_next;
    end

    assign busy     = busy_reg;
    assign quotient = acc_reg[SHIFT +: SAMPLE_W];

endmodule : swmma_div

`default_nettype wire

FILE: rtl/sliding_window_min_max_avg_core.sv
// Sliding window min/max/mean core: top level with ring control and scan.
// Depends on swmma_pkg, swmma_ram and swmma_div.
`default_nettype none

// Each input beat carries one unsigned Q16.8 time sample. The sample overwrites
// the ring entry at the write pointer (which then wraps over WINDOW entries), and
// one result beat reports the minimum, maximum and truncated mean over all WINDOW
// entries together with the sample just written. Entries never written since
// reset count as zero. After reset the block runs a clearing pass, zeroing one
// ring entry per cycle, with s_ready held low. Each item then goes through these
// steps: the idle state reads the old entry, the old-entry state writes the new
// sample and updates a running sum, and the scan state reads all WINDOW entries
// through the single read port of the ring RAM to find min and max, takes in the
// last read, and publishes into the output register. The mean comes from
// a reciprocal-multiply divider of the running sum that runs alongside the scan,
// one 16-bit digit per cycle, and the result is published only once both the
// divider and the scan have finished. The next item is taken once the result is
// in the output register, even while that result still waits for m_ready; a
// result still waiting when the next scan ends holds that item until it leaves.
module sliding_window_min_max_avg_core
    import swmma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [SAMPLE_W-1:0] s_sample_ms,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [SAMPLE_W-1:0] m_window_min,
    output logic      [SAMPLE_W-1:0] m_window_max,
    output logic      [SAMPLE_W-1:0] m_window_mean,
    output logic      [SAMPLE_W-1:0] m_latest_sample
);

    localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  SCAN_END  = CNT_W'(WINDOW);

    // State and control registers
    swmma_state_t      state_reg, state_next;
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              m_valid_reg, m_valid_next;

    // Datapath registers
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [SAMPLE_W-1:0] out_min_reg, out_min_next;
    logic [SAMPLE_W-1:0] out_max_reg, out_max_next;
    logic [SAMPLE_W-1:0] out_mean_reg, out_mean_next;
    logic [SAMPLE_W-1:0] out_latest_reg, out_latest_next;

    // Ring RAM port signals
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    // Divider
    logic                div_start;
    logic                div_busy;
    logic [SAMPLE_W-1:0] div_quotient;

    logic s_accept;
    logic out_free;
    logic scan_done;

    swmma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW),
        .ADDR_W(ADDR_W)
    ) u_ring (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    swmma_div #(
        .WINDOW(WINDOW),
        .SUM_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(sum_next),
        .busy    (div_busy),
        .quotient(div_quotient)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_done = (scan_cnt_reg == SCAN_END) && !rd_pend_reg && !div_busy;

    always_comb begin
        state_next      = state_reg;
        wr_ptr_next     = wr_ptr_reg;
        clr_cnt_next    = clr_cnt_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_pend_next    = 1'b0;
        sum_next        = sum_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        sample_next     = sample_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;
        out_mean_next   = out_mean_reg;
        out_latest_next = out_latest_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg;
        ram_wdata       = sample_reg;
        ram_re          = 1'b0;
        ram_raddr       = wr_ptr_reg;
        div_start       = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                // Zero one ring entry per cycle.
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    // Fetch the entry about to be overwritten.
                    sample_next = s_sample_ms;
                    ram_re      = 1'b1;
                    ram_raddr   = wr_ptr_reg;
                    state_next  = ST_OLD;
                end
            end
            ST_OLD: begin
                // Swap the old entry out of the running sum and write the sample.
                sum_next  = sum_reg - SUM_W'(ram_rdata) + SUM_W'(sample_reg);
                ram_we    = 1'b1;
                div_start = 1'b1;
                wr_ptr_next   = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
                scan_cnt_next = '0;
                min_next      = '1;
                max_next      = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_cnt_reg != SCAN_END) begin
                    ram_re        = 1'b1;
                    ram_raddr     = scan_cnt_reg[ADDR_W-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    rd_pend_next  = 1'b1;
                end
                if (rd_pend_reg) begin
                    if (ram_rdata < min_reg) begin
                        min_next = ram_rdata;
                    end
                    if (ram_rdata > max_reg) begin
                        max_next = ram_rdata;
                    end
                end
                // Publish once scan and divide finish and the output slot is free.
                if (scan_done && out_free) begin
                    out_min_next    = min_reg;
                    out_max_next    = max_reg;
                    out_mean_next   = div_quotient;
                    out_latest_next = sample_reg;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            wr_ptr_reg   <= '0;
            clr_cnt_reg  <= '0;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wr_ptr_reg   <= wr_ptr_next;
            clr_cnt_reg  <= clr_cnt_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            sum_reg      <= sum_next;
            m_valid_reg  <= m_valid_next;
        end
        sample_reg     <= sample_next;
        min_reg        <= min_next;
        max_reg        <= max_next;
        out_min_reg    <= out_min_next;
        out_max_reg    <= out_max_next;
        out_mean_reg   <= out_mean_next;
        out_latest_reg <= out_latest_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_window_min    = out_min_reg;
    assign m_window_max    = out_max_reg;
    assign m_window_mean   = out_mean_reg;
    assign m_latest_sample = out_latest_reg;

    // The sample just written lies inside the window, so it is bounded by min and max.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_min_reg <= out_latest_reg) && (out_latest_reg <= out_max_reg))
        else $error("latest sample outside reported min/max");

    // The mean of the window always lies between its min and max.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_min_reg <= out_mean_reg) && (out_mean_reg <= out_max_reg))
        else $error("mean outside reported min/max");

    // A new beat is never taken while the divider still works on the previous one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> !div_busy)
        else $error("input beat accepted while divider busy");

    // A result is published only from the scan state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_SCAN))
        else $error("result published outside the scan");

endmodule : sliding_window_min_max_avg_core

`default_nettype wire
